[sv/lca_pkg.sv]
// ----------------------------------------------------------------------------
// lca_pkg
// Shared types and constants of the binary lifting LCA engine.
// ----------------------------------------------------------------------------
package lca_pkg;

    localparam int FIELD_W   = 10;
    localparam int OP_W      = 2;
    localparam int KIND_W    = 2;
    localparam int IN_DATA_W = 32;
    localparam int OUT_DATA_W = 16;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BUILD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_B_LVL,
        ST_B_RD1,
        ST_B_RD2,
        ST_B_WR,
        ST_Q_D1,
        ST_Q_D2,
        ST_Q_D3,
        ST_L1_RD,
        ST_L1_EV,
        ST_CMP,
        ST_L2_RD,
        ST_L2_EV,
        ST_F_RD,
        ST_F_EV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic dp_we;
        logic jt_we;
    } mem_ctl_t;

endpackage

[sv/lca_mem.sv]
// ----------------------------------------------------------------------------
// lca_mem
// Depth store and ancestor jump table as synchronous memories. The depth
// store has one read port; the jump table has two. Read data is registered.
// ----------------------------------------------------------------------------
module lca_mem #(
    parameter int NODES   = 1024,
    parameter int ENTRIES = 10240,
    localparam int AW = (NODES > 1) ? $clog2(NODES) : 1,
    localparam int TW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                        clk,
    input  lca_pkg::mem_ctl_t           ctl,
    input  logic [AW-1:0]               dp_waddr,
    input  logic [lca_pkg::FIELD_W-1:0] dp_wdata,
    input  logic [AW-1:0]               dp_raddr,
    output logic [lca_pkg::FIELD_W-1:0] dp_rdata,
    input  logic [TW-1:0]               jt_waddr,
    input  logic [lca_pkg::FIELD_W-1:0] jt_wdata,
    input  logic [TW-1:0]               jt_raddr_a,
    input  logic [TW-1:0]               jt_raddr_b,
    output logic [lca_pkg::FIELD_W-1:0] jt_rdata_a,
    output logic [lca_pkg::FIELD_W-1:0] jt_rdata_b
);
    import lca_pkg::*;

    logic [FIELD_W-1:0] dp_mem [NODES];
    logic [FIELD_W-1:0] jt_mem [ENTRIES];

    logic [FIELD_W-1:0] dp_rdata_reg;
    logic [FIELD_W-1:0] jt_rdata_a_reg;
    logic [FIELD_W-1:0] jt_rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.dp_we)
        begin
            dp_mem[dp_waddr] <= dp_wdata;
        end
        dp_rdata_reg <= dp_mem[dp_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.jt_we)
        begin
            jt_mem[jt_waddr] <= jt_wdata;
        end
        jt_rdata_a_reg <= jt_mem[jt_raddr_a];
        jt_rdata_b_reg <= jt_mem[jt_raddr_b];
    end

    assign dp_rdata   = dp_rdata_reg;
    assign jt_rdata_a = jt_rdata_a_reg;
    assign jt_rdata_b = jt_rdata_b_reg;

endmodule

[sv/lca_binary_lifting_engine.sv]
// ----------------------------------------------------------------------------
// Load writes one node's depth and parent. Query lifts from level L, where L
// is floor(log2) of the deeper node's depth capped at JUMP_LEVELS-1; each
// lift step is one jump table read and one evaluate state. Build fills K
// levels over N nodes, each node by read, read, write.
// One item at a time; a result waits in the output register while the next
// item is taken. After reset a clear pass zeroes both memories.
// ----------------------------------------------------------------------------
// lca_binary_lifting_engine
// Lowest common ancestor by binary lifting over a depth store and a jump
// table held in synchronous memories, run by a sequencer.
// ----------------------------------------------------------------------------
module lca_binary_lifting_engine #(
    parameter int MAX_NODES   = 1024,
    parameter int JUMP_LEVELS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lca_pkg::FIELD_W-1:0]   cfg_data,     // node_count
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // node [9:0], other_node [19:10], node_depth [29:20], zero [31:30]
    input  logic [lca_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  logic [lca_pkg::OP_W-1:0]      s_axis_tuser, // opcode
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // ancestor [9:0], zero [15:10]
    output logic [lca_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic [lca_pkg::KIND_W-1:0]    m_axis_tuser  // result_kind
);
    import lca_pkg::*;

    localparam int AW      = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int ENTRIES = MAX_NODES * JUMP_LEVELS;
    localparam int TW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LW      = (JUMP_LEVELS > 1) ? $clog2(JUMP_LEVELS) : 1;
    localparam int LCW     = $clog2(JUMP_LEVELS + 1);
    localparam int SW      = (JUMP_LEVELS + 1 > FIELD_W + 1) ? JUMP_LEVELS + 1 : FIELD_W + 1;

    state_t state_reg, state_next;

    logic [TW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [OP_W-1:0]    op_reg, op_next;
    logic [FIELD_W-1:0] x_reg, x_next;
    logic [FIELD_W-1:0] y_reg, y_next;
    logic [FIELD_W-1:0] d_reg, d_next;
    logic [FIELD_W-1:0] dy_reg, dy_next;
    logic [FIELD_W-1:0] v_reg, v_next;
    logic [LCW-1:0]     lvl_reg, lvl_next;
    logic [LW-1:0]      j_reg, j_next;
    logic [LW-1:0]      top_reg, top_next;
    logic               has_top_reg, has_top_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [FIELD_W-1:0] anc_reg, anc_next;
    logic [FIELD_W-1:0] node_count_reg, node_count_next;
    logic               m_valid_reg, m_valid_next;
    logic [KIND_W-1:0]  m_kind_reg, m_kind_next;
    logic [FIELD_W-1:0] m_anc_reg, m_anc_next;

    mem_ctl_t           mem_ctl;
    logic [AW-1:0]      dp_waddr, dp_raddr;
    logic [FIELD_W-1:0] dp_wdata, dp_rdata;
    logic [TW-1:0]      jt_waddr, jt_raddr_a, jt_raddr_b;
    logic [FIELD_W-1:0] jt_wdata, jt_rdata_a, jt_rdata_b;

    logic [LCW-1:0]     lvl_m1;
    logic [LW-1:0]      lvl_prev, lvl_cur;
    logic [FIELD_W-1:0] last_node;
    logic               in_fire, out_load, query_bad, level_ok;
    logic               swap_c, has_top_c, lift_c;
    logic [FIELD_W-1:0] dx_c;
    logic [LW-1:0]      top_c;

    function automatic logic [TW-1:0] jt_addr(input logic [FIELD_W-1:0] n,
                                              input logic [LW-1:0] l);
        return TW'(AW'(n)) * TW'(JUMP_LEVELS) + TW'(l);
    endfunction

    lca_mem #(
        .NODES   (MAX_NODES),
        .ENTRIES (ENTRIES)
    ) u_lca_mem (
        .clk        (clk),
        .ctl        (mem_ctl),
        .dp_waddr   (dp_waddr),
        .dp_wdata   (dp_wdata),
        .dp_raddr   (dp_raddr),
        .dp_rdata   (dp_rdata),
        .jt_waddr   (jt_waddr),
        .jt_wdata   (jt_wdata),
        .jt_raddr_a (jt_raddr_a),
        .jt_raddr_b (jt_raddr_b),
        .jt_rdata_a (jt_rdata_a),
        .jt_rdata_b (jt_rdata_b)
    );

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign out_load  = (state_reg == ST_DONE) && (!m_valid_reg || m_axis_tready);
    assign lvl_m1    = lvl_reg - LCW'(1);
    assign lvl_prev  = lvl_m1[LW-1:0];
    assign lvl_cur   = lvl_reg[LW-1:0];
    assign last_node = (32'(node_count_reg) > (MAX_NODES - 1)) ?
                       FIELD_W'(MAX_NODES - 1) : node_count_reg;
    assign query_bad = (32'(x_reg) >= MAX_NODES) || (32'(y_reg) >= MAX_NODES);
    assign level_ok  = (32'(lvl_reg) < JUMP_LEVELS) &&
                       ((SW'(1) << lvl_reg) <= SW'(node_count_reg));

    // The deeper node becomes x; top is the highest level not above its depth.
    assign swap_c = d_reg < dp_rdata;
    assign dx_c   = swap_c ? dp_rdata : d_reg;

    always_comb
    begin
        top_c     = '0;
        has_top_c = 1'b0;
        for (int k = 0; k < JUMP_LEVELS; k++)
        begin
            if ((SW'(1) << k) <= SW'(dx_c))
            begin
                top_c     = LW'(k);
                has_top_c = 1'b1;
            end
        end
    end

    // dp_rdata holds the depth of the current x while evaluating a lift.
    assign lift_c = SW'(dp_rdata) >= (SW'(dy_reg) + (SW'(1) << j_reg));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == TW'(ENTRIES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (s_axis_tuser)
                        OP_LOAD:  state_next = ST_LOAD;
                        OP_BUILD: state_next = ST_B_LVL;
                        OP_QUERY: state_next = ST_Q_D1;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_LOAD:  state_next = ST_DONE;
            ST_B_LVL: state_next = level_ok ? ST_B_RD1 : ST_DONE;
            ST_B_RD1: state_next = ST_B_RD2;
            ST_B_RD2: state_next = ST_B_WR;
            ST_B_WR:  state_next = (v_reg == last_node) ? ST_B_LVL : ST_B_RD1;
            ST_Q_D1:  state_next = query_bad ? ST_DONE : ST_Q_D2;
            ST_Q_D2:  state_next = ST_Q_D3;
            ST_Q_D3:  state_next = has_top_c ? ST_L1_RD : ST_CMP;
            ST_L1_RD: state_next = ST_L1_EV;
            ST_L1_EV: state_next = (j_reg == '0) ? ST_CMP : ST_L1_RD;
            ST_CMP:
            begin
                if (x_reg == y_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = has_top_reg ? ST_L2_RD : ST_F_RD;
                end
            end
            ST_L2_RD: state_next = ST_L2_EV;
            ST_L2_EV: state_next = (j_reg == '0) ? ST_F_RD : ST_L2_RD;
            ST_F_RD:  state_next = ST_F_EV;
            ST_F_EV:  state_next = ST_DONE;
            ST_DONE:  state_next = out_load ? ST_IDLE : ST_DONE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Memory control, addresses and handshake outputs.
    always_comb
    begin
        mem_ctl       = '0;
        dp_waddr      = AW'(x_reg);
        dp_wdata      = d_reg;
        dp_raddr      = AW'(x_reg);
        jt_waddr      = jt_addr(x_reg, '0);
        jt_wdata      = (32'(y_reg) < MAX_NODES) ? y_reg : '0;
        jt_raddr_a    = jt_addr(x_reg, j_reg);
        jt_raddr_b    = jt_addr(y_reg, j_reg);
        s_axis_tready = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_ctl.jt_we = 1'b1;
                mem_ctl.dp_we = 32'(clr_cnt_reg) < MAX_NODES;
                jt_waddr      = clr_cnt_reg;
                jt_wdata      = '0;
                dp_waddr      = AW'(clr_cnt_reg);
                dp_wdata      = '0;
            end
            ST_LOAD:
            begin
                // A load does not write the sentinel or nodes past the store.
                mem_ctl.jt_we = (x_reg != '0) && (32'(x_reg) < MAX_NODES);
                mem_ctl.dp_we = (x_reg != '0) && (32'(x_reg) < MAX_NODES);
            end
            ST_B_RD1: jt_raddr_a = jt_addr(v_reg, lvl_prev);
            ST_B_RD2: jt_raddr_a = jt_addr(jt_rdata_a, lvl_prev);
            ST_B_WR:
            begin
                mem_ctl.jt_we = 1'b1;
                jt_waddr      = jt_addr(v_reg, lvl_cur);
                jt_wdata      = jt_rdata_a;
            end
            ST_Q_D2:  dp_raddr = AW'(y_reg);
            ST_F_RD:  jt_raddr_a = jt_addr(x_reg, '0);
            default:
            begin
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        clr_cnt_next    = clr_cnt_reg;
        op_next         = op_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        d_next          = d_reg;
        dy_next         = dy_reg;
        v_next          = v_reg;
        lvl_next        = lvl_reg;
        j_next          = j_reg;
        top_next        = top_reg;
        has_top_next    = has_top_reg;
        kind_next       = kind_reg;
        anc_next        = anc_reg;
        node_count_next = cfg_valid ? cfg_data : node_count_reg;
        m_valid_next    = m_valid_reg;
        m_kind_next     = m_kind_reg;
        m_anc_next      = m_anc_reg;

        if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (out_load)
        begin
            m_valid_next = 1'b1;
            m_kind_next  = kind_reg;
            m_anc_next   = anc_reg;
        end

        case (state_reg)
            ST_CLEAR: clr_cnt_next = clr_cnt_reg + TW'(1);
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    op_next  = s_axis_tuser;
                    x_next   = s_axis_tdata[FIELD_W-1:0];
                    y_next   = s_axis_tdata[2*FIELD_W-1:FIELD_W];
                    d_next   = s_axis_tdata[3*FIELD_W-1:2*FIELD_W];
                    anc_next = '0;
                    lvl_next = LCW'(1);
                    v_next   = FIELD_W'(1);
                    case (s_axis_tuser)
                        OP_BUILD: kind_next = KIND_BUILD;
                        OP_QUERY: kind_next = KIND_QUERY;
                        default:  kind_next = KIND_LOAD;
                    endcase
                end
            end
            ST_Q_D2: d_next = dp_rdata;
            ST_Q_D3:
            begin
                if (swap_c)
                begin
                    x_next = y_reg;
                    y_next = x_reg;
                end
                dy_next      = swap_c ? d_reg : dp_rdata;
                top_next     = top_c;
                j_next       = top_c;
                has_top_next = has_top_c;
            end
            ST_B_WR:
            begin
                if (v_reg == last_node)
                begin
                    v_next   = FIELD_W'(1);
                    lvl_next = lvl_reg + LCW'(1);
                end
                else
                begin
                    v_next = v_reg + FIELD_W'(1);
                end
            end
            ST_L1_EV:
            begin
                if (lift_c)
                begin
                    x_next = jt_rdata_a;
                end
                j_next = j_reg - LW'(1);
            end
            ST_CMP:
            begin
                anc_next = x_reg;
                j_next   = top_reg;
            end
            ST_L2_EV:
            begin
                if (jt_rdata_a != jt_rdata_b)
                begin
                    x_next = jt_rdata_a;
                    y_next = jt_rdata_b;
                end
                j_next = j_reg - LW'(1);
            end
            ST_F_EV: anc_next = jt_rdata_a;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            node_count_reg <= FIELD_W'(1);
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            node_count_reg <= node_count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        d_reg       <= d_next;
        dy_reg      <= dy_next;
        v_reg       <= v_next;
        lvl_reg     <= lvl_next;
        j_reg       <= j_next;
        top_reg     <= top_next;
        has_top_reg <= has_top_next;
        kind_reg    <= kind_next;
        anc_reg     <= (op_reg == OP_QUERY) ? anc_next : '0;
        m_kind_reg  <= m_kind_next;
        m_anc_reg   <= m_anc_next;
    end

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_kind_reg;
    assign m_axis_tdata  = OUT_DATA_W'(m_anc_reg);

endmodule

[sv/lca_checker.sv]
// ----------------------------------------------------------------------------
// lca_checker
// Port-level checks of the LCA engine, bound to the top level.
// ----------------------------------------------------------------------------
module lca_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [lca_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [lca_pkg::KIND_W-1:0]     m_axis_tuser
);
    import lca_pkg::*;

    // A result that waits must not change under the consumer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Only one item is in work: the input closes right after a transaction.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    // Loads, builds and unknown opcodes carry a zero ancestor.
    a_zero_anc: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != KIND_QUERY) |-> (m_axis_tdata == '0))
        else $error("nonzero ancestor on a non-query result");

    // Result kinds stay within the defined codes and the padding stays zero.
    a_kind_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (m_axis_tuser == KIND_LOAD || m_axis_tuser == KIND_BUILD ||
             m_axis_tuser == KIND_QUERY) &&
            (m_axis_tdata[OUT_DATA_W-1:FIELD_W] == '0))
        else $error("bad result kind or padding");

endmodule

bind lca_binary_lifting_engine lca_checker u_lca_checker (.*);
